// ===== hw/rtl/ghash_pkg.sv =====
// ----------------------------------------------------------------------------
// GHASH package
// Operation codes, register indexes, block sizes and the GF(2^128) multiply
// used by the GHASH accumulator.
// ----------------------------------------------------------------------------
package ghash_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_AAD    = 2'd0;
    localparam logic [1:0] OP_TEXT   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_BITS  = 128;
    localparam int COUNT_BITS  = 64;
    localparam int NB_BITS     = 5;

    // Valid byte count at which a block is full.
    localparam logic [NB_BITS-1:0] FULL_BLOCK = 5'd16;

    typedef logic [BLOCK_BITS-1:0] block_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // Multiply two field elements in GCM bit order. Bit 127 of the vector
    // (top bit of byte 0) is the coefficient of x^0. The product is formed
    // as a carry-less multiply and reduced by x^128 = x^7 + x^2 + x + 1.
    function automatic block_t gf128_mul(input block_t a_vec, input block_t b_vec);
        logic [BLOCK_BITS-1:0]   a_poly;
        logic [BLOCK_BITS-1:0]   b_poly;
        logic [2*BLOCK_BITS-2:0] prod;
        logic [BLOCK_BITS+5:0]   fold;
        logic [BLOCK_BITS-1:0]   red;
        block_t                  res;
        for (int i = 0; i < BLOCK_BITS; i++)
        begin
            a_poly[i] = a_vec[BLOCK_BITS-1-i];
            b_poly[i] = b_vec[BLOCK_BITS-1-i];
        end
        // Carry-less product, one independent XOR tree per coefficient.
        for (int k = 0; k < 2*BLOCK_BITS-1; k++)
        begin
            prod[k] = 1'b0;
            for (int i = 0; i < BLOCK_BITS; i++)
            begin
                if ((k - i >= 0) && (k - i < BLOCK_BITS))
                begin
                    prod[k] = prod[k] ^ (a_poly[i] & b_poly[k-i]);
                end
            end
        end
        // First fold of the upper coefficients.
        fold = {6'd0, prod[BLOCK_BITS-1:0]};
        for (int k = BLOCK_BITS; k < 2*BLOCK_BITS-1; k++)
        begin
            fold[k-128] = fold[k-128] ^ prod[k];
            fold[k-127] = fold[k-127] ^ prod[k];
            fold[k-126] = fold[k-126] ^ prod[k];
            fold[k-121] = fold[k-121] ^ prod[k];
        end
        // Second fold of the few coefficients the first one pushed past x^127.
        red = fold[BLOCK_BITS-1:0];
        for (int k = BLOCK_BITS; k < BLOCK_BITS+6; k++)
        begin
            red[k-128] = red[k-128] ^ fold[k];
            red[k-127] = red[k-127] ^ fold[k];
            red[k-126] = red[k-126] ^ fold[k];
            red[k-121] = red[k-121] ^ fold[k];
        end
        for (int i = 0; i < BLOCK_BITS; i++)
        begin
            res[BLOCK_BITS-1-i] = red[i];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/ghash_accumulator.sv =====
// ----------------------------------------------------------------------------
// GHASH accumulator
// Running GCM hash over AAD and ciphertext blocks with a finish step that
// folds in the length block and emits the 128-bit hash.
// ----------------------------------------------------------------------------
// Usage:
//   Write the hash subkey H through the configuration channel (index 0 for
//   bytes 0..7, index 1 for bytes 8..15) while the block is idle.
//   Each word on s_axis carries one block: tuser is the operation (AAD,
//   ciphertext or finish) and tdata holds the two data halves and the valid
//   byte count. Blocks are absorbed into the accumulator with one multiply
//   by H each; a finish word folds in the bit counts, multiplies once more,
//   places the hash on m_axis and clears the accumulator and both counters.
//   Throughput is one word per cycle: the input register feeds a single
//   combinational GF(2^128) multiplier whose product lands in the
//   accumulator register, or on finish in the result register that
//   drives m_axis. When the receiver stalls, absorb words keep flowing;
//   only a second finish waits in the input register until the held
//   hash is taken. Reset clears the key, accumulator, counters and all
//   valid flags.
// ----------------------------------------------------------------------------
module ghash_accumulator
(
    input  logic           clk,
    input  logic           rst_n,
    // Configuration write channel.
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [63:0]    cfg_data,
    // Input blocks.
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // tdata fields from bit 0: data_high[63:0], data_low[127:64],
    // byte_count[132:128], zero fill[135:133].
    input  logic [135:0]   s_axis_tdata,
    // tuser fields from bit 0: operation[1:0].
    input  logic [1:0]     s_axis_tuser,
    // Hash results.
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // tdata fields from bit 0: hash_high[63:0], hash_low[127:64].
    output logic [127:0]   m_axis_tdata
);

    logic                        key_high_en;
    logic                        key_low_en;
    ghash_pkg::count_t           key_high_reg;
    ghash_pkg::count_t           key_low_reg;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [1:0]                  s1_op_reg;
    ghash_pkg::block_t           s1_data_reg;
    logic [ghash_pkg::NB_BITS-1:0] s1_count_reg;

    ghash_pkg::block_t           accum_reg;
    ghash_pkg::block_t           accum_next;
    ghash_pkg::count_t           aad_count_reg;
    ghash_pkg::count_t           aad_count_next;
    ghash_pkg::count_t           text_count_reg;
    ghash_pkg::count_t           text_count_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    ghash_pkg::block_t           out_data_reg;
    ghash_pkg::block_t           out_data_next;

    logic                        in_fire;
    logic                        s1_go;
    logic                        s1_fire;
    logic [ghash_pkg::NB_BITS-1:0] nb_sat;
    ghash_pkg::block_t           byte_mask;
    ghash_pkg::block_t           block_in;
    ghash_pkg::block_t           mul_operand;
    ghash_pkg::block_t           product;
    ghash_pkg::count_t           count_add;
    ghash_pkg::count_t           aad_sum;
    ghash_pkg::count_t           text_sum;
    logic [ghash_pkg::COUNT_BITS:0] aad_wide;
    logic [ghash_pkg::COUNT_BITS:0] text_wide;

    // Configuration writes are always taken.
    assign cfg_ready   = 1'b1;
    assign key_high_en = cfg_valid && (cfg_index == ghash_pkg::CFG_KEY_HIGH);
    assign key_low_en  = cfg_valid && (cfg_index == ghash_pkg::CFG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else
        begin
            if (key_high_en)
            begin
                key_high_reg <= cfg_data;
            end
            if (key_low_en)
            begin
                key_low_reg <= cfg_data;
            end
        end
    end

    // A finish word waits only while a previous hash is still held.
    assign s1_go   = !((s1_op_reg == ghash_pkg::OP_FINISH) && out_valid_reg
                       && !m_axis_tready);
    assign s1_fire = s1_valid_reg && s1_go;
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= s_axis_tuser;
            s1_data_reg  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            s1_count_reg <= s_axis_tdata[132:128];
        end
    end

    // Zero the bytes past the valid count; counts above a full block saturate.
    assign nb_sat = (s1_count_reg > ghash_pkg::FULL_BLOCK) ? ghash_pkg::FULL_BLOCK
                                                            : s1_count_reg;

    always_comb
    begin
        for (int b = 0; b < ghash_pkg::BLOCK_BYTES; b++)
        begin
            byte_mask[ghash_pkg::BLOCK_BITS-1-8*b -: 8] =
                (ghash_pkg::NB_BITS'(b) < nb_sat) ? 8'hFF : 8'h00;
        end
    end

    assign block_in = s1_data_reg & byte_mask;

    // Multiplier operand: the accumulator XOR the data block, or XOR the length block on finish.
    assign mul_operand = (s1_op_reg == ghash_pkg::OP_FINISH)
                         ? (accum_reg ^ {aad_count_reg, text_count_reg})
                         : (accum_reg ^ block_in);
    assign product = ghash_pkg::gf128_mul(mul_operand, {key_high_reg, key_low_reg});

    // Saturating bit counters.
    assign count_add = {{(ghash_pkg::COUNT_BITS-ghash_pkg::NB_BITS-3){1'b0}}, nb_sat, 3'b000};
    assign aad_wide  = {1'b0, aad_count_reg} + {1'b0, count_add};
    assign text_wide = {1'b0, text_count_reg} + {1'b0, count_add};
    assign aad_sum   = aad_wide[ghash_pkg::COUNT_BITS] ? '1
                                                       : aad_wide[ghash_pkg::COUNT_BITS-1:0];
    assign text_sum  = text_wide[ghash_pkg::COUNT_BITS] ? '1
                                                        : text_wide[ghash_pkg::COUNT_BITS-1:0];

    // Next state of the accumulator, counters and result register.
    always_comb
    begin
        accum_next      = accum_reg;
        aad_count_next  = aad_count_reg;
        text_count_next = text_count_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        if (s1_fire)
        begin
            case (s1_op_reg)
                ghash_pkg::OP_AAD:
                begin
                    accum_next     = product;
                    aad_count_next = aad_sum;
                end
                ghash_pkg::OP_TEXT:
                begin
                    accum_next      = product;
                    text_count_next = text_sum;
                end
                ghash_pkg::OP_FINISH:
                begin
                    accum_next      = '0;
                    aad_count_next  = '0;
                    text_count_next = '0;
                    out_data_next   = product;
                    out_valid_next  = 1'b1;
                end
                default:
                begin
                    accum_next = accum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg      <= '0;
            aad_count_reg  <= '0;
            text_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            accum_reg      <= accum_next;
            aad_count_reg  <= aad_count_next;
            text_count_reg <= text_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Output word: hash_high in the low half, hash_low above it.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg[63:0], out_data_reg[127:64]};

endmodule
